[design/lfk_pkg.sv]
`timescale 1ns / 1ps

package lfk_pkg;

    // Register map
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_LATERAL_OFFSET = 2'd0;
    localparam logic [1:0] REG_HIP_DROP       = 2'd1;
    localparam logic [1:0] REG_UPPER_LENGTH   = 2'd2;
    localparam logic [1:0] REG_LOWER_LENGTH   = 2'd3;

    localparam logic [15:0] RST_LATERAL_OFFSET = 16'd3604;
    localparam logic [15:0] RST_HIP_DROP       = 16'd3932;
    localparam logic [15:0] RST_UPPER_LENGTH   = 16'd13107;
    localparam logic [15:0] RST_LOWER_LENGTH   = 16'd13107;

    // CORDIC gain in Q30
    localparam longint GAIN_Q30 = 64'sd652032874;

    // Square root unit
    localparam int SUM_W    = 42;
    localparam int SQ_W     = 43;
    localparam int SQ_STEPS = 21;
    localparam int SQ_LAT   = SQ_STEPS + 2;
    localparam logic [19:0] DIST_MAX = 20'hFFFFF;

    typedef struct packed {
        logic [15:0]        angle_hip_yaw;
        logic [15:0]        angle_hip_roll;
        logic [15:0]        angle_hip_pitch;
        logic [15:0]        angle_knee;
        logic [15:0]        angle_ankle;
        logic signed [19:0] target_x;
        logic signed [19:0] target_y;
        logic signed [19:0] target_z;
    } t_in_item;

    typedef struct packed {
        logic signed [19:0] foot_x;
        logic signed [19:0] foot_y;
        logic signed [19:0] foot_z;
        logic [19:0]        distance;
    } t_out_item;

    // Arctangent table, 2^32 per turn
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051D;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2E;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2F9;
            15: v = 32'h0000517C;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A2F;
            19: v = 32'h00000517;
            20: v = 32'h0000028B;
            21: v = 32'h00000145;
            22: v = 32'h000000A2;
            23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

[design/leg_forward_kinematics_distance.sv]
`timescale 1ns / 1ps

// Leg forward kinematics with foot-to-target distance.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one transfer carries
// five joint angles (16-bit binary angles) and a target point (Q16 metres).
// Output channel (o_out_valid / i_out_ready / o_out_data): one transfer per
// input with the foot position and its Euclidean distance to the target.
// Link lengths sit in four APB registers at byte addresses 0, 4, 8, 12;
// write them only while the pipeline is empty.
//
// Throughput: one item per cycle while the receiver is not stalling. Each
// item passes through the sine and cosine CORDIC, then the chain products
// and squares, then the bit-per-stage square root.
//
// Reset empties the pipeline and loads the default link lengths. When the
// receiver stalls, the whole pipeline holds and o_in_ready drops; nothing is
// dropped or repeated.

module leg_forward_kinematics_distance #(
    parameter int TRIG_FRACTION_BITS = 15,
    parameter int CORDIC_STAGES      = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  lfk_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output lfk_pkg::t_out_item          o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfk_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int F   = TRIG_FRACTION_BITS;
    localparam int TW  = F + 3;
    localparam int MW  = 24;
    localparam int L_C = CORDIC_STAGES + 2;
    localparam int DT  = L_C + 6;
    localparam int NF  = lfk_pkg::SQ_LAT + 3;
    localparam int L   = L_C + 8 + lfk_pkg::SQ_LAT;
    localparam logic signed [MW+TW-1:0] RND = (MW+TW)'(1) <<< (F - 1);

    typedef struct packed {
        logic signed [TW-1:0] c0;
        logic signed [TW-1:0] s0;
        logic signed [TW-1:0] c1;
        logic signed [TW-1:0] s1;
        logic signed [TW-1:0] c2;
        logic signed [TW-1:0] s2;
    } t_trig;

    typedef struct packed {
        logic signed [19:0] fx;
        logic signed [19:0] fy;
        logic signed [19:0] fz;
    } t_foot;

    // Length times trig value, rounded
    function automatic logic signed [MW-1:0] f_mulr(input logic signed [MW-1:0] v,
                                                    input logic signed [TW-1:0] t);
        logic signed [MW+TW-1:0] p;
        p = (MW+TW)'(v) * (MW+TW)'(t);
        p = (p + RND) >>> F;
        return p[MW-1:0];
    endfunction

    function automatic logic signed [19:0] f_sat(input logic signed [MW-1:0] v);
        logic signed [19:0] r;
        if (v > MW'(524287)) begin
            r = 20'sd524287;
        end else if (v < -MW'(524288)) begin
            r = -20'sd524288;
        end else begin
            r = v[19:0];
        end
        return r;
    endfunction

    // ---------------- configuration ----------------
    logic [15:0] r_lateral, r_hip_drop, r_upper, r_lower;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lateral  <= lfk_pkg::RST_LATERAL_OFFSET;
            r_hip_drop <= lfk_pkg::RST_HIP_DROP;
            r_upper    <= lfk_pkg::RST_UPPER_LENGTH;
            r_lower    <= lfk_pkg::RST_LOWER_LENGTH;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                lfk_pkg::REG_LATERAL_OFFSET: r_lateral  <= pwdata[15:0];
                lfk_pkg::REG_HIP_DROP:       r_hip_drop <= pwdata[15:0];
                lfk_pkg::REG_UPPER_LENGTH:   r_upper    <= pwdata[15:0];
                lfk_pkg::REG_LOWER_LENGTH:   r_lower    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            lfk_pkg::REG_LATERAL_OFFSET: prdata = {16'd0, r_lateral};
            lfk_pkg::REG_HIP_DROP:       prdata = {16'd0, r_hip_drop};
            lfk_pkg::REG_UPPER_LENGTH:   prdata = {16'd0, r_upper};
            lfk_pkg::REG_LOWER_LENGTH:   prdata = {16'd0, r_lower};
            default:                     prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // Advance everything together whenever the output register is free.
    logic en;
    logic r_vld [0:L-1];

    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < L; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < L; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Target delay line, meets the foot at the difference stage
    lfk_pkg::t_in_item r_tgt [0:DT-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tgt[0] <= i_in_data;
            for (int k = 1; k < DT; k++) begin
                r_tgt[k] <= r_tgt[k-1];
            end
        end
    end

    // ---------------- sine and cosine, four lanes ----------------
    logic signed [TW-1:0] co [0:3];
    logic signed [TW-1:0] si [0:3];
    logic [15:0]          lane_angle [0:3];

    assign lane_angle[0] = i_in_data.angle_hip_yaw;
    assign lane_angle[1] = i_in_data.angle_hip_roll;
    assign lane_angle[2] = i_in_data.angle_hip_pitch;
    assign lane_angle[3] = i_in_data.angle_knee;

    for (genvar j = 0; j < 4; j++) begin : g_lane
        lfk_cordic #(
            .F      (F),
            .STAGES (CORDIC_STAGES)
        ) u_cordic (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_angle (lane_angle[j]),
            .o_cos   (co[j]),
            .o_sin   (si[j])
        );
    end

    // Hold the first three joints' trig values until their stage comes up
    t_trig r_trig [0:3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_trig[0] <= '{c0: co[0], s0: si[0], c1: co[1], s1: si[1],
                           c2: co[2], s2: si[2]};
            for (int k = 1; k < 4; k++) begin
                r_trig[k] <= r_trig[k-1];
            end
        end
    end

    // ---------------- chain, outermost link first ----------------
    logic signed [MW-1:0] r_x3, r_y3;
    logic signed [MW-1:0] r_pa, r_pb, r_pc, r_pd;
    logic signed [MW-1:0] r_x2, r_px;
    logic signed [MW-1:0] r_py, r_pz, r_px_d;
    logic signed [MW-1:0] r_q1, r_q2, r_q3, r_q4, r_pz_e;
    t_foot                r_foot [0:NF-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            // knee: lower leg rotated, upper leg added
            r_x3 <= MW'(r_upper) + f_mulr(MW'(r_lower), co[3]);
            r_y3 <= f_mulr(MW'(r_lower), si[3]);
            // hip pitch products
            r_pa <= f_mulr(r_x3, r_trig[0].c2);
            r_pb <= f_mulr(r_y3, r_trig[0].s2);
            r_pc <= f_mulr(r_x3, r_trig[0].s2);
            r_pd <= f_mulr(r_y3, r_trig[0].c2);
            // combine; Rx(-90) turns y into -x
            r_x2 <= r_pa - r_pb;
            r_px <= -(r_pc + r_pd);
            // hip roll after Ry(+90) and the hip drop
            r_py   <= f_mulr(r_x2, r_trig[2].s1);
            r_pz   <= -(MW'(r_hip_drop) + f_mulr(r_x2, r_trig[2].c1));
            r_px_d <= r_px;
            // hip yaw products
            r_q1   <= f_mulr(r_px_d, r_trig[3].c0);
            r_q2   <= f_mulr(r_py, r_trig[3].s0);
            r_q3   <= f_mulr(r_px_d, r_trig[3].s0);
            r_q4   <= f_mulr(r_py, r_trig[3].c0);
            r_pz_e <= r_pz;
            // foot, lateral offset applied as -y
            r_foot[0] <= '{fx: f_sat(r_q1 - r_q2),
                           fy: f_sat(r_q3 + r_q4 - MW'(r_lateral)),
                           fz: f_sat(r_pz_e)};
            for (int k = 1; k < NF; k++) begin
                r_foot[k] <= r_foot[k-1];
            end
        end
    end

    // ---------------- distance ----------------
    logic signed [20:0]               d [0:2];
    logic [lfk_pkg::SUM_W-1:0]        r_sq [0:2];
    logic [lfk_pkg::SUM_W-1:0]        r_sum;
    logic [19:0]                      root;

    assign d[0] = 21'(r_foot[0].fx) - 21'(r_tgt[DT-1].target_x);
    assign d[1] = 21'(r_foot[0].fy) - 21'(r_tgt[DT-1].target_y);
    assign d[2] = 21'(r_foot[0].fz) - 21'(r_tgt[DT-1].target_z);

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= lfk_pkg::SUM_W'($unsigned(42'(d[k]) * 42'(d[k])));
            end
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    lfk_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sum  (r_sum),
        .o_root (root)
    );

    assign o_out_data = '{foot_x:   r_foot[NF-1].fx,
                          foot_y:   r_foot[NF-1].fy,
                          foot_z:   r_foot[NF-1].fz,
                          distance: root};

    // ---------------- checks ----------------
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld[0]) && $stable(r_vld[L/2]) && $stable(o_out_valid))
        else $error("pipeline moved during a stall");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !r_vld[L-2] |=> !o_out_valid)
        else $error("output valid without an item behind it");

    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cfg_wr |=> $stable(r_lateral) && $stable(r_hip_drop) &&
                    $stable(r_upper) && $stable(r_lower))
        else $error("link length changed without a write");

endmodule

[design/lfk_cordic.sv]
`timescale 1ns / 1ps

module lfk_cordic #(
    parameter int F      = 15,
    parameter int STAGES = 16
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [15:0]         i_angle,
    output logic signed [F+2:0] o_cos,
    output logic signed [F+2:0] o_sin
);

    localparam int TW = F + 3;
    localparam int ZW = 34;
    localparam longint K_VAL =
        (lfk_pkg::GAIN_Q30 + (64'sd1 <<< (29 - F))) >>> (30 - F);

    logic signed [TW-1:0] r_x [0:STAGES];
    logic signed [TW-1:0] r_y [0:STAGES];
    logic signed [ZW-1:0] r_z [0:STAGES];
    logic                 r_neg [0:STAGES];

    logic signed [15:0] ang_in;
    logic signed [16:0] ang_res;
    logic               ang_neg;

    // Fold into the right half plane
    always_comb begin
        ang_in  = $signed(i_angle);
        ang_res = 17'(ang_in);
        ang_neg = 1'b0;
        if (ang_in > 16'sd16384) begin
            ang_res = 17'(ang_in) - 17'sd32768;
            ang_neg = 1'b1;
        end else if (ang_in < -16'sd16384) begin
            ang_res = 17'(ang_in) + 17'sd32768;
            ang_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= TW'(K_VAL);
            r_y[0]   <= '0;
            r_z[0]   <= {ang_res[16], ang_res, 16'd0};
            r_neg[0] <= ang_neg;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [ZW-1:0] ATAN_I = ZW'(lfk_pkg::atan_turn(i));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][ZW-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ATAN_I;
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ATAN_I;
                end
                r_neg[i+1] <= r_neg[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= r_neg[STAGES] ? -r_x[STAGES] : r_x[STAGES];
            o_sin <= r_neg[STAGES] ? -r_y[STAGES] : r_y[STAGES];
        end
    end

endmodule

[design/lfk_isqrt.sv]
`timescale 1ns / 1ps

module lfk_isqrt (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [lfk_pkg::SUM_W-1:0]  i_sum,
    output logic [19:0]                o_root
);

    localparam int W = lfk_pkg::SQ_W;
    localparam int N = lfk_pkg::SQ_STEPS;

    logic [W-1:0] r_rem  [0:N];
    logic [W-1:0] r_root [0:N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= W'(i_sum);
            r_root[0] <= '0;
        end
    end

    // One result bit per stage
    for (genvar i = 0; i < N; i++) begin : g_step
        localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - i));
        logic [W-1:0] trial;
        assign trial = r_root[i] + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_rem[i] >= trial) begin
                    r_rem[i+1]  <= r_rem[i] - trial;
                    r_root[i+1] <= (r_root[i] >> 1) + BIT;
                end else begin
                    r_rem[i+1]  <= r_rem[i];
                    r_root[i+1] <= r_root[i] >> 1;
                end
            end
        end
    end

    // Round to nearest, then clamp
    logic [W-1:0] rounded;
    assign rounded = (r_rem[N] > r_root[N]) ? r_root[N] + W'(1) : r_root[N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_root <= (rounded > W'(lfk_pkg::DIST_MAX)) ? lfk_pkg::DIST_MAX : rounded[19:0];
        end
    end

endmodule

[verif/lfk_checker.sv]
`timescale 1ns / 1ps

module lfk_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  lfk_pkg::t_in_item          i_in_data,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  lfk_pkg::t_out_item         i_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [lfk_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output int                         o_fail_count,
    output int                         o_pending
);
    localparam int FRAC = 15;
    localparam int STAGES = 16;

    longint lat_off, hip_drop_len, upper_len, lower_len;
    lfk_pkg::t_out_item foot_q[$];

    assign o_pending = foot_q.size();

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint mul_trig(longint v, longint t);
        return fshift(v * t + (64'sd1 <<< (FRAC - 1)), FRAC);
    endfunction

    function automatic void cordic_sincos(logic [15:0] a, output longint c,
                                          output longint s);
        longint ang, x, y, z, dx, dy;
        bit flip;
        ang = longint'($signed(a));
        flip = 0;
        if (ang > 16384) begin
            ang -= 32768;
            flip = 1;
        end else if (ang < -16384) begin
            ang += 32768;
            flip = 1;
        end
        x = (lfk_pkg::GAIN_Q30 + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
        y = 0;
        z = ang * 65536;
        for (int i = 0; i < STAGES; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= longint'(lfk_pkg::atan_turn(i));
            end else begin
                x += dx;
                y -= dy;
                z += longint'(lfk_pkg::atan_turn(i));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint clamp20(longint v);
        if (v > 524287) return 524287;
        if (v < -524288) return -524288;
        return v;
    endfunction

    function automatic longint round_sqrt(longint unsigned v);
        longint unsigned r, b, rem;
        r = 0;
        b = 64'd1 << 62;
        rem = v;
        while (b > rem) b >>= 2;
        while (b != 0) begin
            if (rem >= r + b) begin
                rem -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        if (rem > r) r++;
        return r;
    endfunction

    function automatic lfk_pkg::t_out_item foot_position(lfk_pkg::t_in_item it);
        longint c0, s0, c1, s1, c2, s2, c3, s3;
        longint x3, y3, x2, y2, px, py, pz, fx, fy, fz, dx, dy, dz, d;
        lfk_pkg::t_out_item r;
        cordic_sincos(it.angle_hip_yaw, c0, s0);
        cordic_sincos(it.angle_hip_roll, c1, s1);
        cordic_sincos(it.angle_hip_pitch, c2, s2);
        cordic_sincos(it.angle_knee, c3, s3);
        x3 = upper_len + mul_trig(lower_len, c3);
        y3 = mul_trig(lower_len, s3);
        x2 = mul_trig(x3, c2) - mul_trig(y3, s2);
        y2 = mul_trig(x3, s2) + mul_trig(y3, c2);
        px = -y2;
        py = mul_trig(x2, s1);
        pz = -(hip_drop_len + mul_trig(x2, c1));
        fx = clamp20(mul_trig(px, c0) - mul_trig(py, s0));
        fy = clamp20(mul_trig(px, s0) + mul_trig(py, c0) - lat_off);
        fz = clamp20(pz);
        dx = fx - longint'(it.target_x);
        dy = fy - longint'(it.target_y);
        dz = fz - longint'(it.target_z);
        d = round_sqrt(dx * dx + dy * dy + dz * dz);
        if (d > 1048575) d = 1048575;
        r.foot_x = fx[19:0];
        r.foot_y = fy[19:0];
        r.foot_z = fz[19:0];
        r.distance = d[19:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        lfk_pkg::t_out_item exp_item;
        if (!i_rst_n) begin
            lat_off <= lfk_pkg::RST_LATERAL_OFFSET;
            hip_drop_len <= lfk_pkg::RST_HIP_DROP;
            upper_len <= lfk_pkg::RST_UPPER_LENGTH;
            lower_len <= lfk_pkg::RST_LOWER_LENGTH;
            foot_q.delete();
            o_fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    lfk_pkg::REG_LATERAL_OFFSET: lat_off <= pwdata[15:0];
                    lfk_pkg::REG_HIP_DROP:       hip_drop_len <= pwdata[15:0];
                    lfk_pkg::REG_UPPER_LENGTH:   upper_len <= pwdata[15:0];
                    lfk_pkg::REG_LOWER_LENGTH:   lower_len <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                foot_q.insert(foot_q.size(), foot_position(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (foot_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result %h", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_item = foot_q.pop_front();
                    if (exp_item !== i_out_data) begin
                        if (o_fail_count < 10)
                            $display("mismatch x %0d/%0d y %0d/%0d z %0d/%0d d %0d/%0d",
                                exp_item.foot_x, i_out_data.foot_x,
                                exp_item.foot_y, i_out_data.foot_y,
                                exp_item.foot_z, i_out_data.foot_z,
                                exp_item.distance, i_out_data.distance);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

    // Pipeline depth with default parameters, plus margin for the final drain
    localparam int DRAIN_CYCLES = 80;
    // Idle cycles allowed before the run is declared hung
    localparam int HANG_LIMIT = 2000;

    logic i_clk, i_rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    lfk_pkg::t_in_item in_data;
    lfk_pkg::t_out_item out_data;
    logic psel, penable, pwrite, pready;
    logic [lfk_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    int fail_count, pending;
    bit calm;      // no idling on either side near the end
    int idle_cycles = 0;

    leg_forward_kinematics_distance dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    lfk_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: count cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: stall in random bursts, never once calm
    initial begin
        int n;
        out_ready = 0;
        @(negedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 3);
                out_ready = 0;
                repeat (n) @(negedge i_clk);
            end else begin
                out_ready = 1;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
        end
    end

    // Drive one transfer; hold valid and payload until accepted
    task automatic send_item(lfk_pkg::t_in_item it);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid = 0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_valid = 1;
        in_data = it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
        in_valid = 0;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel = 1; penable = 0; pwrite = 1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge i_clk);
        penable = 1;
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    // Wait until every expected result has come back, then let the pipe settle
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [19:0] rand_target(bit full);
        if (full) return 20'($urandom);
        return 20'($urandom_range(0, 131072) - 65536);
    endfunction

    function automatic lfk_pkg::t_in_item rand_item(bit full_targets);
        lfk_pkg::t_in_item it;
        it.angle_hip_yaw   = 16'($urandom);
        it.angle_hip_roll  = 16'($urandom);
        it.angle_hip_pitch = 16'($urandom);
        it.angle_knee      = 16'($urandom);
        it.angle_ankle     = 16'($urandom);
        it.target_x = rand_target(full_targets);
        it.target_y = rand_target(full_targets);
        it.target_z = rand_target(full_targets);
        return it;
    endfunction

    initial begin
        lfk_pkg::t_in_item it;
        logic [15:0] corner_angles [8] = '{16'h0000, 16'h4000, 16'h4001, 16'h8000,
                                           16'hBFFF, 16'hC000, 16'hFFFF, 16'h7FFF};
        logic [19:0] corner_targets [4] = '{20'h00000, 20'h7FFFF, 20'h80000, 20'hFFFFF};
        calm = 0;
        in_valid = 0;
        in_data = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        i_rst_n = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1;

        // Directed: angle wrap points, quadrant edges and target extremes
        for (int i = 0; i < 8; i++) begin
            it.angle_hip_yaw   = corner_angles[i];
            it.angle_hip_roll  = corner_angles[(i + 1) % 8];
            it.angle_hip_pitch = corner_angles[(i + 3) % 8];
            it.angle_knee      = corner_angles[(i + 5) % 8];
            it.angle_ankle     = corner_angles[7 - i];
            it.target_x = corner_targets[i % 4];
            it.target_y = corner_targets[(i + 1) % 4];
            it.target_z = corner_targets[(i + 2) % 4];
            send_item(it);
        end
        drain();

        // Maximum lengths, with targets drawn from the extreme corners
        write_reg(lfk_pkg::REG_LATERAL_OFFSET, 32'hFFFFFFFF);
        write_reg(lfk_pkg::REG_HIP_DROP, 32'h0001FFFF);
        write_reg(lfk_pkg::REG_UPPER_LENGTH, 32'hFFFF);
        write_reg(lfk_pkg::REG_LOWER_LENGTH, 32'hFFFF);
        for (int i = 0; i < 8; i++) begin
            it = '0;
            it.angle_hip_roll = corner_angles[i];
            it.target_x = corner_targets[(i + 2) % 4];
            it.target_y = corner_targets[(i + 2) % 4];
            it.target_z = corner_targets[(i + 1) % 4];
            send_item(it);
        end
        drain();

        // Random phases over several length settings, last phase calm
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 0) begin
                write_reg(lfk_pkg::REG_LATERAL_OFFSET, 0);
                write_reg(lfk_pkg::REG_HIP_DROP, 0);
                write_reg(lfk_pkg::REG_UPPER_LENGTH, 0);
                write_reg(lfk_pkg::REG_LOWER_LENGTH, 0);
            end else begin
                write_reg(lfk_pkg::REG_LATERAL_OFFSET, $urandom);
                write_reg(lfk_pkg::REG_HIP_DROP, $urandom);
                write_reg(lfk_pkg::REG_UPPER_LENGTH, $urandom);
                write_reg(lfk_pkg::REG_LOWER_LENGTH, $urandom);
            end
            if (ph == 3) calm = 1;
            for (int i = 0; i < 100; i++)
                send_item(rand_item($urandom_range(0, 3) == 0));
            drain();
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

[filelist.f]
design/lfk_pkg.sv
design/lfk_cordic.sv
design/lfk_isqrt.sv
design/leg_forward_kinematics_distance.sv
verif/lfk_checker.sv
verif/tb.sv
